[hdl/mot_pkg.sv]
// Package for the MOT object segment tracker.
// Holds status codes, the slide content type and the types shared by the cells and the top level.
// Depends on nothing.
`default_nettype none
package mot_pkg;

    // Result status codes.
    localparam logic [2:0] ST_HDR_NEW = 3'd0;
    localparam logic [2:0] ST_HDR_DUP = 3'd1;
    localparam logic [2:0] ST_SEG_NEW = 3'd2;
    localparam logic [2:0] ST_SEG_DUP = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_RANGE   = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    // Content type of a slide, whose marks are cleared on completion.
    localparam logic [5:0] SLIDE_TYPE = 6'd2;

    // Widest slot index (up to 64 entries) and widest count (up to 1024 segments).
    localparam int IDX_MAX_W = 6;
    localparam int CNT_MAX_W = 11;

    // Search token that travels along the chain of cells.
    typedef struct packed {
        logic                 vld;
        logic [15:0]          tid;
        logic                 found;
        logic [IDX_MAX_W-1:0] midx;
        logic                 free;
        logic [IDX_MAX_W-1:0] fidx;
    } t_tok;

    // Contents of one table slot.
    typedef struct packed {
        logic                 valid;
        logic [15:0]          tid;
        logic [27:0]          body_size;
        logic [5:0]           ctype;
        logic [8:0]           csub;
        logic [12:0]          seg_size;
        logic                 size_known;
        logic [CNT_MAX_W-1:0] seg_count;
        logic                 count_known;
    } t_slot;

    // Update command broadcast to all cells.
    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] idx;
        logic                 hdr;
        logic [15:0]          tid;
        logic [27:0]          body_size;
        logic [5:0]           ctype;
        logic [8:0]           csub;
        logic                 size_en;
        logic [12:0]          seg_size;
        logic                 cnt_en;
        logic [CNT_MAX_W-1:0] seg_count;
    } t_wr;

endpackage
`default_nettype wire

[hdl/mot_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module mot_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[hdl/mot_cell.sv]
// One slot of the tracker table: holds the slot and passes the search token onwards.
// Depends on mot_pkg.
`default_nettype none
module mot_cell #(
    parameter int IDX = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mot_pkg::t_tok i_tok,
    input  wire mot_pkg::t_wr  i_wr,
    output mot_pkg::t_tok      o_tok,
    output mot_pkg::t_slot     o_slot
);
    import mot_pkg::*;

    t_slot r_slot;
    t_tok  r_tok;
    t_tok  n_tok;
    logic  w_sel;

    assign w_sel = i_wr.en && (i_wr.idx == IDX_MAX_W'(IDX));

    // Match on the transport id and note the lowest free slot.
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.free && !r_slot.valid) begin
            n_tok.free = 1'b1;
            n_tok.fidx = IDX_MAX_W'(IDX);
        end
        if (r_slot.valid && (r_slot.tid == i_tok.tid)) begin
            n_tok.found = 1'b1;
            n_tok.midx  = IDX_MAX_W'(IDX);
        end
    end

    // Token register towards the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Slot contents; only the valid flag needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else if (w_sel && i_wr.hdr) begin
            r_slot.valid <= 1'b1;
        end
        if (w_sel) begin
            if (i_wr.hdr) begin
                r_slot.tid         <= i_wr.tid;
                r_slot.body_size   <= i_wr.body_size;
                r_slot.ctype       <= i_wr.ctype;
                r_slot.csub        <= i_wr.csub;
                r_slot.seg_size    <= '0;
                r_slot.size_known  <= 1'b0;
                r_slot.seg_count   <= '0;
                r_slot.count_known <= 1'b0;
            end
            if (i_wr.size_en) begin
                r_slot.seg_size   <= i_wr.seg_size;
                r_slot.size_known <= 1'b1;
            end
            if (i_wr.cnt_en) begin
                r_slot.seg_count   <= i_wr.seg_count;
                r_slot.count_known <= 1'b1;
            end
        end
    end

    assign o_tok  = r_tok;
    assign o_slot = r_slot;
endmodule
`default_nettype wire

[hdl/mot_object_segment_tracker_top.sv]
// Top level of the MOT object segment tracker: control sequencer, chain of slot cells
// and the segment mark RAM. Depends on mot_pkg, mot_cell and mot_ram.
//
//   Channel | Direction | Handshake          | Payload
//   input   | in        | i_valid / o_ready  | opcode, ids, segment data, header data
//   result  | out       | o_valid / i_ready  | status, slot, eviction and completion data
//
// A header, an unknown id or a segment number beyond the table goes, from one acceptance
// to the next, through the walk of the search token along the chain of cells and its
// capture in S_SCAN, the decision in S_LOOK and the hand-over of the result in S_PUSH,
// after which the result and o_ready rise together. A duplicate segment also passes
// S_READ for the mark row read, and any other segment S_READ and then S_MUL for the size
// check. One item is worked on at a time.
// Reset empties the table at once; the mark RAM needs no clearing since a row is
// zeroed whenever its slot is created. A stalled result holds the next item in its
// final state until the result register is free.
`default_nettype none
module mot_object_segment_tracker_top #(
    parameter int ENTRIES  = 16,
    parameter int SEGMENTS = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_transport_id,
    input  wire logic [14:0] i_segment_number,
    input  wire logic [12:0] i_segment_size,
    input  wire logic        i_last_segment,
    input  wire logic [27:0] i_body_size,
    input  wire logic [5:0]  i_content_type,
    input  wire logic [8:0]  i_content_subtype,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [3:0]       o_entry_index,
    output logic             o_evicted,
    output logic [15:0]      o_evicted_transport_id,
    output logic [7:0]       o_segment_count,
    output logic [27:0]      o_done_body_size,
    output logic [5:0]       o_done_content_type,
    output logic [8:0]       o_done_content_subtype
);
    import mot_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int SW = $clog2(SEGMENTS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_LOOK = 6'b000100,
        S_READ = 6'b001000,
        S_MUL  = 6'b010000,
        S_PUSH = 6'b100000
    } t_state;

    t_state r_state;

    // Latched input transaction.
    logic        r_op;
    logic [15:0] r_tid;
    logic [14:0] r_segno;
    logic [12:0] r_ssize;
    logic        r_last;
    logic [27:0] r_bsize;
    logic [5:0]  r_ctype;
    logic [8:0]  r_csub;

    // Search outcome and work registers.
    logic                r_found;
    logic [IW-1:0]       r_midx;
    logic                r_free;
    logic [IW-1:0]       r_fidx;
    logic [IW-1:0]       r_ptr;
    logic [SEGMENTS-1:0] r_row;
    logic                r_known;
    logic [27:0]         r_prod;

    // Pending result.
    logic [2:0]  r_res_status;
    logic [IW-1:0] r_res_idx;
    logic        r_res_ev;
    logic [15:0] r_res_evtid;
    logic [7:0]  r_res_cnt;
    logic [27:0] r_res_body;
    logic [5:0]  r_res_ctype;
    logic [8:0]  r_res_csub;

    t_tok  w_tok_in;
    t_tok  w_tok [ENTRIES];
    t_slot w_slot [ENTRIES];
    t_wr   w_wr;
    t_slot w_ms;

    logic                w_we;
    logic [IW-1:0]       w_waddr;
    logic [SEGMENTS-1:0] w_wdata;
    logic                w_re;
    logic [SEGMENTS-1:0] w_rdata;

    logic                 w_accept;
    logic [SW-1:0]        w_sidx;
    logic [12:0]          w_eff_size;
    logic                 w_eff_known;
    logic [28:0]          w_end;
    logic [CNT_MAX_W-1:0] w_cnt;
    logic                 w_cntk;
    logic [SEGMENTS-1:0]  w_mask;
    logic [SEGMENTS-1:0]  w_newrow;
    logic                 w_done;

    logic [2:0]           w_lk_status;
    logic [IW-1:0]        w_lk_idx;
    logic                 w_lk_ev;
    logic                 w_lk_go;

    assign o_ready  = i_rst_n && (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_sidx   = r_segno[SW-1:0];
    assign w_ms     = w_slot[r_midx];

    // Token entering the first cell.
    always_comb begin
        w_tok_in     = '0;
        w_tok_in.vld = w_accept;
        w_tok_in.tid = i_transport_id;
    end

    // Chain of slot cells.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mot_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  ((g == 0) ? w_tok_in : w_tok[(g == 0) ? 0 : g - 1]),
            .i_wr   (w_wr),
            .o_tok  (w_tok[g]),
            .o_slot (w_slot[g])
        );
    end

    // Segment mark rows, one per slot.
    mot_ram #(.WIDTH(SEGMENTS), .DEPTH(ENTRIES)) u_marks (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(r_midx),
        .o_rdata(w_rdata)
    );

    // Segment size in effect: the stored one if known, else this transaction's, known unless last.
    assign w_eff_known = w_ms.size_known || !r_last;
    assign w_eff_size  = w_ms.size_known ? w_ms.seg_size : r_ssize;

    // Bound check and completion check on the product from the previous cycle.
    assign w_end  = {1'b0, r_prod} + 29'(r_ssize);
    assign w_cnt  = r_last ? (CNT_MAX_W'(r_segno) + CNT_MAX_W'(1)) : w_ms.seg_count;
    assign w_cntk = r_last || w_ms.count_known;
    always_comb begin
        for (int k = 0; k < SEGMENTS; k++) begin
            w_mask[k] = (CNT_MAX_W'(k) < w_cnt);
        end
        w_newrow = r_row;
        w_newrow[w_sidx] = 1'b1;
    end
    assign w_done = w_cntk && (&(w_newrow | ~w_mask));

    // Outcome of the search: status, slot, eviction and whether the mark row is needed.
    always_comb begin
        w_lk_status = ST_UNKNOWN;
        w_lk_idx    = '0;
        w_lk_ev     = 1'b0;
        w_lk_go     = 1'b0;
        if (!r_op) begin
            if (r_found) begin
                w_lk_status = ST_HDR_DUP;
                w_lk_idx    = r_midx;
            end else begin
                w_lk_status = ST_HDR_NEW;
                if (r_free) begin
                    w_lk_idx = r_fidx;
                end else begin
                    w_lk_idx = r_ptr;
                    w_lk_ev  = 1'b1;
                end
            end
        end else if (r_found) begin
            w_lk_idx = r_midx;
            if (r_segno >= 15'(SEGMENTS)) begin
                w_lk_status = ST_RANGE;
            end else begin
                w_lk_go = 1'b1;
            end
        end
    end

    // Slot updates and mark row writes issued by the sequencer.
    always_comb begin
        w_wr    = '0;
        w_we    = 1'b0;
        w_waddr = r_midx;
        w_wdata = '0;
        w_re    = 1'b0;
        unique case (r_state)
            S_LOOK: begin
                if (!r_op && !r_found) begin
                    w_wr.en        = 1'b1;
                    w_wr.idx       = IDX_MAX_W'(r_free ? r_fidx : r_ptr);
                    w_wr.hdr       = 1'b1;
                    w_wr.tid       = r_tid;
                    w_wr.body_size = r_bsize;
                    w_wr.ctype     = r_ctype;
                    w_wr.csub      = r_csub;
                    w_we           = 1'b1;
                    w_waddr        = r_free ? r_fidx : r_ptr;
                end else if (r_op && r_found) begin
                    w_re = 1'b1;
                end
            end
            S_READ: begin
                if (!w_rdata[w_sidx] && !r_last && !w_ms.size_known) begin
                    w_wr.en       = 1'b1;
                    w_wr.idx      = IDX_MAX_W'(r_midx);
                    w_wr.size_en  = 1'b1;
                    w_wr.seg_size = r_ssize;
                end
            end
            S_MUL: begin
                if (!(r_known && (w_end > 29'(w_ms.body_size)))) begin
                    w_we    = 1'b1;
                    w_wdata = (w_done && (w_ms.ctype == SLIDE_TYPE)) ?
                              (w_newrow & ~w_mask) : w_newrow;
                    if (r_last) begin
                        w_wr.en        = 1'b1;
                        w_wr.idx       = IDX_MAX_W'(r_midx);
                        w_wr.cnt_en    = 1'b1;
                        w_wr.seg_count = w_cnt;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Input latch.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_opcode;
            r_tid   <= i_transport_id;
            r_segno <= i_segment_number;
            r_ssize <= i_segment_size;
            r_last  <= i_last_segment;
            r_bsize <= i_body_size;
            r_ctype <= i_content_type;
            r_csub  <= i_content_subtype;
        end
    end

    // Sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && (r_state != S_PUSH)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[ENTRIES-1].vld) begin
                        r_found <= w_tok[ENTRIES-1].found;
                        r_midx  <= w_tok[ENTRIES-1].midx[IW-1:0];
                        r_free  <= w_tok[ENTRIES-1].free;
                        r_fidx  <= w_tok[ENTRIES-1].fidx[IW-1:0];
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_res_status <= w_lk_status;
                    r_res_idx    <= w_lk_idx;
                    r_res_ev     <= w_lk_ev;
                    r_res_evtid  <= w_lk_ev ? w_slot[r_ptr].tid : '0;
                    r_res_cnt    <= '0;
                    r_res_body   <= '0;
                    r_res_ctype  <= '0;
                    r_res_csub   <= '0;
                    r_state      <= w_lk_go ? S_READ : S_PUSH;
                    if (w_lk_ev) begin
                        r_ptr <= (r_ptr == IW'(ENTRIES - 1)) ? '0 : r_ptr + 1'b1;
                    end
                end
                S_READ: begin
                    r_row   <= w_rdata;
                    r_known <= w_eff_known;
                    r_prod  <= 28'(r_segno) * 28'(w_eff_size);
                    if (w_rdata[w_sidx]) begin
                        r_res_status <= ST_SEG_DUP;
                        r_state      <= S_PUSH;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_PUSH;
                    if (r_known && (w_end > 29'(w_ms.body_size))) begin
                        r_res_status <= ST_RANGE;
                    end else if (w_done) begin
                        r_res_status <= ST_DONE;
                        r_res_cnt    <= w_cnt[7:0];
                        r_res_body   <= w_ms.body_size;
                        r_res_ctype  <= w_ms.ctype;
                        r_res_csub   <= w_ms.csub;
                    end else begin
                        r_res_status <= ST_SEG_NEW;
                    end
                end
                S_PUSH: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output transaction register.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_PUSH) && (!o_valid || i_ready)) begin
            o_status               <= r_res_status;
            o_entry_index          <= 4'(r_res_idx);
            o_evicted              <= r_res_ev;
            o_evicted_transport_id <= r_res_evtid;
            o_segment_count        <= r_res_cnt;
            o_done_body_size       <= r_res_body;
            o_done_content_type    <= r_res_ctype;
            o_done_content_subtype <= r_res_csub;
        end
    end
endmodule
`default_nettype wire

[test/mot_tracker_checker.sv]
// Checker for the MOT object segment tracker: watches both channels, predicts each result
// from its own copy of the slot table and segment marks, and compares field by field.
// Depends on mot_pkg.
`default_nettype none
module mot_tracker_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready_in,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_transport_id,
    input  wire logic [14:0] i_segment_number,
    input  wire logic [12:0] i_segment_size,
    input  wire logic        i_last_segment,
    input  wire logic [27:0] i_body_size,
    input  wire logic [5:0]  i_content_type,
    input  wire logic [8:0]  i_content_subtype,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [2:0]  i_status,
    input  wire logic [3:0]  i_entry_index,
    input  wire logic        i_evicted,
    input  wire logic [15:0] i_evicted_transport_id,
    input  wire logic [7:0]  i_segment_count,
    input  wire logic [27:0] i_done_body_size,
    input  wire logic [5:0]  i_done_content_type,
    input  wire logic [8:0]  i_done_content_subtype,
    output int               o_errors,
    output int               o_pending
);
    import mot_pkg::*;

    localparam int NSLOT = 16;
    localparam int NSEG  = 128;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  idx;
        logic        evicted;
        logic [15:0] ev_tid;
        logic [7:0]  count;
        logic [27:0] body;
        logic [5:0]  ctype;
        logic [8:0]  csub;
    } t_outcome;

    logic              tbl_valid [NSLOT];
    logic [15:0]       tbl_tid   [NSLOT];
    logic [27:0]       tbl_body  [NSLOT];
    logic [5:0]        tbl_type  [NSLOT];
    logic [8:0]        tbl_sub   [NSLOT];
    logic [12:0]       tbl_ssize [NSLOT];
    logic              tbl_sknown[NSLOT];
    logic [7:0]        tbl_count [NSLOT];
    logic              tbl_cknown[NSLOT];
    logic [NSEG-1:0]   tbl_marks [NSLOT];
    logic [3:0]        oldest_ptr;
    t_outcome          outcome_q[$];

    // Work out the result of one accepted transaction and update the table.
    function automatic t_outcome track_item();
        t_outcome r;
        int s;
        int f;
        logic [63:0] seg_end;
        logic done;
        r = '0;
        s = -1;
        f = -1;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_tid[i] == i_transport_id) s = i;
            if (!tbl_valid[i]) f = i;
        end
        if (i_opcode == 1'b0) begin
            if (s >= 0) begin
                r.status = ST_HDR_DUP;
                r.idx = s[3:0];
                return r;
            end
            if (f < 0) begin
                f = oldest_ptr;
                oldest_ptr = oldest_ptr + 4'd1;
                r.evicted = 1'b1;
                r.ev_tid = tbl_tid[f];
            end
            tbl_valid[f] = 1'b1;
            tbl_tid[f] = i_transport_id;
            tbl_body[f] = i_body_size;
            tbl_type[f] = i_content_type;
            tbl_sub[f] = i_content_subtype;
            tbl_ssize[f] = '0;
            tbl_sknown[f] = 1'b0;
            tbl_count[f] = '0;
            tbl_cknown[f] = 1'b0;
            tbl_marks[f] = '0;
            r.status = ST_HDR_NEW;
            r.idx = f[3:0];
            return r;
        end
        if (s < 0) begin
            r.status = ST_UNKNOWN;
            return r;
        end
        r.idx = s[3:0];
        if (i_segment_number >= NSEG) begin
            r.status = ST_RANGE;
            return r;
        end
        if (tbl_marks[s][i_segment_number]) begin
            r.status = ST_SEG_DUP;
            return r;
        end
        if (!i_last_segment && !tbl_sknown[s]) begin
            tbl_ssize[s] = i_segment_size;
            tbl_sknown[s] = 1'b1;
        end
        if (tbl_sknown[s]) begin
            seg_end = 64'(i_segment_number) * 64'(tbl_ssize[s]) + 64'(i_segment_size);
            if (seg_end > 64'(tbl_body[s])) begin
                r.status = ST_RANGE;
                return r;
            end
        end
        tbl_marks[s][i_segment_number] = 1'b1;
        if (i_last_segment) begin
            tbl_count[s] = 8'(i_segment_number + 1);
            tbl_cknown[s] = 1'b1;
        end
        done = tbl_cknown[s];
        for (int k = 0; k < NSEG; k++)
            if (k < tbl_count[s] && !tbl_marks[s][k]) done = 1'b0;
        if (done) begin
            r.status = ST_DONE;
            r.count = tbl_count[s];
            r.body = tbl_body[s];
            r.ctype = tbl_type[s];
            r.csub = tbl_sub[s];
            // A slide may complete again, so its marks are dropped.
            if (tbl_type[s] == SLIDE_TYPE)
                for (int k = 0; k < NSEG; k++)
                    if (k < tbl_count[s]) tbl_marks[s][k] = 1'b0;
            return r;
        end
        r.status = ST_SEG_NEW;
        return r;
    endfunction

    // Predict on each input transaction and compare on each result transaction.
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_tid[i] = '0;
                tbl_marks[i] = '0;
            end
            oldest_ptr = '0;
            outcome_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_entry_index, i_evicted, i_evicted_transport_id,
                        i_segment_count, i_done_body_size, i_done_content_type,
                        i_done_content_subtype};
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, got);
                    o_errors++;
                end else begin
                    want = outcome_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_errors++;
                    end
                end
            end
            if (i_valid && i_ready_in) outcome_q.push_back(track_item());
        end
        o_pending = outcome_q.size();
    end
endmodule
`default_nettype wire

[test/tb_mot_object_segment_tracker_top.sv]
// Testbench top for the MOT object segment tracker: clock, reset, directed and random
// transactions with bursty sending and a stalling receiver; verdict from the checker.
// Depends on mot_pkg, mot_object_segment_tracker_top and mot_tracker_checker.
`default_nettype none
module tb_mot_object_segment_tracker_top;
    import mot_pkg::*;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_BODY   = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [15:0] tid;
    logic [14:0] segno;
    logic [12:0] ssize;
    logic        last_seg;
    logic [27:0] body;
    logic [5:0]  ctype;
    logic [8:0]  csub;
    logic        res_valid;
    logic        res_ready;
    logic [2:0]  status;
    logic [3:0]  entry;
    logic        evicted;
    logic [15:0] ev_tid;
    logic [7:0]  count;
    logic [27:0] done_body;
    logic [5:0]  done_type;
    logic [8:0]  done_sub;
    int          errors;
    int          pending;
    int          n_sent;
    logic        hold_off;
    logic [15:0] live_ids[$];

    mot_object_segment_tracker_top uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_ready(in_ready),
        .i_opcode(opcode), .i_transport_id(tid), .i_segment_number(segno),
        .i_segment_size(ssize), .i_last_segment(last_seg), .i_body_size(body),
        .i_content_type(ctype), .i_content_subtype(csub),
        .o_valid(res_valid), .i_ready(res_ready), .o_status(status),
        .o_entry_index(entry), .o_evicted(evicted), .o_evicted_transport_id(ev_tid),
        .o_segment_count(count), .o_done_body_size(done_body),
        .o_done_content_type(done_type), .o_done_content_subtype(done_sub)
    );

    mot_tracker_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_ready_in(in_ready),
        .i_opcode(opcode), .i_transport_id(tid), .i_segment_number(segno),
        .i_segment_size(ssize), .i_last_segment(last_seg), .i_body_size(body),
        .i_content_type(ctype), .i_content_subtype(csub),
        .i_out_valid(res_valid), .i_out_ready(res_ready), .i_status(status),
        .i_entry_index(entry), .i_evicted(evicted), .i_evicted_transport_id(ev_tid),
        .i_segment_count(count), .i_done_body_size(done_body),
        .i_done_content_type(done_type), .i_done_content_subtype(done_sub),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Offer one transaction at the next falling edge and hold it until it is taken.
    task automatic send(input logic op, input logic [15:0] id, input logic [14:0] sn,
                        input logic [12:0] sz, input logic lst, input logic [27:0] bs,
                        input logic [5:0] ct, input logic [8:0] cs);
        @(negedge clk);
        opcode <= op;
        tid <= id;
        segno <= sn;
        ssize <= sz;
        last_seg <= lst;
        body <= bs;
        ctype <= ct;
        csub <= cs;
        in_valid <= 1'b1;
        n_sent++;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Random gap between bursts on the sending side.
    task automatic maybe_gap();
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
    endtask

    // Send a whole object: header then segments in shuffled order, sometimes with noise.
    task automatic send_object(input logic [15:0] id, input int nseg);
        int seg_bytes;
        int order[$];
        logic [5:0] ct;
        seg_bytes = $urandom_range(1, 400);
        ct = ($urandom_range(0, 2) == 0) ? SLIDE_TYPE : 6'($urandom);
        send(OP_HEADER, id, 15'($urandom), 13'($urandom), 1'($urandom),
             28'((nseg - 1) * seg_bytes + $urandom_range(1, seg_bytes)),
             ct, 9'($urandom));
        for (int k = 0; k < nseg; k++) order.push_back(k);
        order.shuffle();
        foreach (order[j]) begin
            maybe_gap();
            send(OP_BODY, id, 15'(order[j]),
                 13'((order[j] == nseg - 1) ? $urandom_range(1, seg_bytes) : seg_bytes),
                 order[j] == nseg - 1, 28'($urandom), 6'($urandom), 9'($urandom));
            if ($urandom_range(0, 9) == 0)
                send(OP_BODY, id, 15'(order[$urandom_range(0, j)]), 13'(seg_bytes),
                     1'($urandom), 28'($urandom), 6'($urandom), 9'($urandom));
        end
    endtask

    // Receiver stalls on a pattern of its own, with one long hold-off on request.
    initial begin
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off) res_ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0) res_ready <= ~res_ready;
            else if ($urandom_range(0, 19) == 0) res_ready <= 1'b1;
        end
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [15:0] id;
        in_valid = 1'b0;
        opcode = 1'b0;
        tid = '0;
        segno = '0;
        ssize = '0;
        last_seg = 1'b0;
        body = '0;
        ctype = '0;
        csub = '0;
        hold_off = 1'b0;
        n_sent = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: unknown id, extremes, duplicates, range, size check and slide repeat.
        send(OP_BODY, 16'hFFFF, 15'h7FFF, 13'h1FFF, 1'b1, '1, '1, '1);
        send(OP_HEADER, 16'hFFFF, 15'h7FFF, 13'h1FFF, 1'b1, 28'hFFFFFFF, 6'h3F, 9'h1FF);
        send(OP_HEADER, 16'hFFFF, '0, '0, 1'b0, '0, '0, '0);
        send(OP_BODY, 16'hFFFF, 15'h7FFF, 13'h1FFF, 1'b0, '0, '0, '0);
        send(OP_BODY, 16'hFFFF, 15'd127, 13'h1FFF, 1'b1, '0, '0, '0);
        send(OP_BODY, 16'hFFFF, 15'd127, 13'h1FFF, 1'b1, '0, '0, '0);
        send(OP_HEADER, 16'h0000, '0, '0, 1'b0, 28'd20, SLIDE_TYPE, 9'h0AA);
        send(OP_BODY, 16'h0000, 15'd0, 13'd10, 1'b0, '0, '0, '0);
        send(OP_BODY, 16'h0000, 15'd2, 13'd10, 1'b1, '0, '0, '0);
        send(OP_BODY, 16'h0000, 15'd1, 13'd10, 1'b1, '0, '0, '0);
        send(OP_BODY, 16'h0000, 15'd0, 13'd10, 1'b0, '0, '0, '0);
        send(OP_BODY, 16'h0000, 15'd1, 13'd10, 1'b1, '0, '0, '0);
        send(OP_BODY, 16'h0000, 15'd1, 13'd10, 1'b1, '0, '0, '0);
        for (int i = 1; i <= 17; i++)
            send(OP_HEADER, 16'(i * 3001), '0, '0, 1'b0, 28'd50, 6'(i), 9'(i));

        // Long receiver hold-off while items keep coming, so the input stalls.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send(OP_BODY, 16'(i * 3001), 15'(i), 13'd5, 1'b0, '0, '0, '0);
        join

        // Sender pauses until everything expected has come back.
        while (pending != 0) @(negedge clk);

        // Random: mostly whole objects over a small id pool, the rest noise.
        while (n_sent < 1850) begin
            maybe_gap();
            if ($urandom_range(0, 3) != 0) begin
                id = 16'($urandom_range(0, 40));
                if ($urandom_range(0, 9) == 0) id = 16'($urandom);
                send_object(id, ($urandom_range(0, 15) == 0) ? $urandom_range(60, 128)
                                                              : $urandom_range(1, 6));
            end else begin
                send(1'($urandom), 16'($urandom_range(0, 40)),
                     ($urandom_range(0, 4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 8)),
                     13'($urandom), 1'($urandom), 28'($urandom), 6'($urandom),
                     9'($urandom));
            end
        end

        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
